@@ rtl/prl_pkg.sv @@
// Package for the per-priority rate limiter: field widths, register indexes,
// reset values and the level-to-pool map. No dependencies.
package prl_pkg;

    localparam int PRL_NUM_POOLS  = 5;
    localparam int PRL_LEVEL_W    = 3;
    localparam int PRL_POOL_MAP_W = 3;
    localparam int PRL_SPACE_W    = 64;
    localparam int PRL_LOG_W      = 6;
    localparam int PRL_TS_W       = 64;
    localparam int PRL_WLEN_W     = 32;
    localparam int PRL_BURST_W    = 16;
    localparam int PRL_CNT_W      = 21;
    localparam int PRL_DROP_W     = 32;
    localparam int PRL_CFG_IDX_W  = 1;
    localparam int PRL_CFG_DATA_W = 32;

    // burst scaling: above the knee, burst * (k - bias) / 4
    localparam logic [PRL_LOG_W-1:0] PRL_BURST_KNEE = 6'd20;
    localparam logic [PRL_LOG_W-1:0] PRL_BURST_BIAS = 6'd16;
    localparam int                   PRL_BURST_SHIFT = 2;

    localparam logic [PRL_WLEN_W-1:0]  PRL_WLEN_RESET  = 32'd30000000;
    localparam logic [PRL_BURST_W-1:0] PRL_BURST_RESET = 16'd1000;

    localparam logic [PRL_CNT_W-1:0]  PRL_CNT_MAX  = '1;
    localparam logic [PRL_DROP_W-1:0] PRL_DROP_MAX = '1;

    typedef logic [PRL_CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx PRL_CFG_WINDOW_LENGTH = 1'd0;
    localparam t_cfg_idx PRL_CFG_BURST_LIMIT   = 1'd1;

    // syslog level to pool: 0-2, 3, 4, 5-6, 7
    function automatic logic [PRL_POOL_MAP_W-1:0] prl_level_pool(
        input logic [PRL_LEVEL_W-1:0] level
    );
        logic [PRL_POOL_MAP_W-1:0] pool;
        unique case (level)
            3'd0, 3'd1, 3'd2: pool = 3'd0;
            3'd3:             pool = 3'd1;
            3'd4:             pool = 3'd2;
            3'd5, 3'd6:       pool = 3'd3;
            default:          pool = 3'd4;
        endcase
        return pool;
    endfunction

endpackage

@@ rtl/prl_floor_log2.sv @@
// Floor of log2 of the free-space figure, zero for inputs of zero or one.
// Depends on prl_pkg for the widths.
module prl_floor_log2 (
    input  logic [prl_pkg::PRL_SPACE_W-1:0] i_value,
    output logic [prl_pkg::PRL_LOG_W-1:0]   o_log2
);
    import prl_pkg::*;

    // highest set bit wins
    always_comb begin
        o_log2 = '0;
        for (int i = 1; i < PRL_SPACE_W; i++) begin
            if (i_value[i]) begin
                o_log2 = PRL_LOG_W'(i);
            end
        end
    end

endmodule

@@ rtl/per_priority_rate_limiter_core.sv @@
// Top level of the per-priority fixed-window rate limiter.
// Depends on prl_pkg and prl_floor_log2.
//
// Each item is one message (syslog level, free space, timestamp) and yields
// exactly one result: admit, plus the drop count of the pool when the
// message opens a new window. Levels map to pools (0-2, 3, 4, 5-6, 7); each
// pool keeps a window start, an admitted count and a dropped count in flip-
// flops that reset clears. Window expiry is timestamp - start > window length
// with no wrap; the burst is scaled by floor(log2(free space)) from 2^21 up.
// Writing zero to either register turns limiting off. The block takes one
// item per cycle unless the result side stalls. The level map and log2 of
// the free space sit before the input register, and the pool read-modify-
// write (burst multiply, window compare, counter update) sits between the
// input register and the result register. Back-to-back items to the same
// pool see each other's updates at once. Configuration is written through
// a plain write port, by the user only while idle, not enforced by the block.
module per_priority_rate_limiter_core #(
    parameter int NUM_POOLS = prl_pkg::PRL_NUM_POOLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_cfg_wr_en,
    input  logic [prl_pkg::PRL_CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [prl_pkg::PRL_CFG_DATA_W-1:0]  i_cfg_data,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [prl_pkg::PRL_LEVEL_W-1:0]     i_level,
    input  logic [prl_pkg::PRL_SPACE_W-1:0]     i_free_space,
    input  logic [prl_pkg::PRL_TS_W-1:0]        i_timestamp,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_admit,
    output logic [prl_pkg::PRL_DROP_W-1:0]      o_dropped_report
);
    import prl_pkg::*;

    localparam int POOL_W = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam logic [PRL_POOL_MAP_W:0] NUM_POOLS_C = (PRL_POOL_MAP_W + 1)'(NUM_POOLS);
    localparam logic [POOL_W-1:0]       LAST_POOL   = POOL_W'(NUM_POOLS - 1);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [PRL_WLEN_W-1:0]  r_wlen;
    logic [PRL_BURST_W-1:0] r_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= PRL_WLEN_RESET;
            r_burst <= PRL_BURST_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                PRL_CFG_WINDOW_LENGTH: r_wlen  <= i_cfg_data[PRL_WLEN_W-1:0];
                PRL_CFG_BURST_LIMIT:   r_burst <= i_cfg_data[PRL_BURST_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the result register frees the input register whenever
    // it is empty or being taken.
    // ---------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic in_accept;
    logic fire;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign fire       = r_in_valid && advance;

    // ---------------------------------------------------------------
    // Input stage: map level to a pool and reduce free space to its log2
    // ---------------------------------------------------------------
    logic [PRL_POOL_MAP_W-1:0] map_pool;
    logic [POOL_W-1:0]         n_in_pool;
    logic [PRL_LOG_W-1:0]      n_in_log2;

    logic [POOL_W-1:0]    r_in_pool;
    logic [PRL_LOG_W-1:0] r_in_log2;
    logic [PRL_TS_W-1:0]  r_in_ts;

    assign map_pool = prl_level_pool(i_level);

    // fold pools that do not exist onto the last one
    always_comb begin
        if ({1'b0, map_pool} >= NUM_POOLS_C) begin
            n_in_pool = LAST_POOL;
        end else begin
            n_in_pool = POOL_W'(map_pool);
        end
    end

    prl_floor_log2 u_log2 (
        .i_value (i_free_space),
        .o_log2  (n_in_log2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_pool <= n_in_pool;
            r_in_log2 <= n_in_log2;
            r_in_ts   <= i_timestamp;
        end
    end

    // ---------------------------------------------------------------
    // Pool state
    // ---------------------------------------------------------------
    logic [PRL_TS_W-1:0]   r_win_start [NUM_POOLS];
    logic [PRL_CNT_W-1:0]  r_win_count [NUM_POOLS];
    logic [PRL_DROP_W-1:0] r_drop_cnt  [NUM_POOLS];

    logic [PRL_TS_W-1:0]   cur_start;
    logic [PRL_CNT_W-1:0]  cur_count;
    logic [PRL_DROP_W-1:0] cur_drop;

    assign cur_start = r_win_start[r_in_pool];
    assign cur_count = r_win_count[r_in_pool];
    assign cur_drop  = r_drop_cnt[r_in_pool];

    // ---------------------------------------------------------------
    // Decision: effective burst, window expiry, admit or drop
    // ---------------------------------------------------------------
    logic [PRL_LOG_W-1:0]   k_scale;
    logic [PRL_CNT_W:0]     burst_prod;
    logic [PRL_CNT_W-1:0]   eff_burst;
    logic [PRL_TS_W-1:0]    elapsed;
    logic                   disabled;
    logic                   open_new;
    logic                   under_burst;

    logic                   n_admit;
    logic [PRL_DROP_W-1:0]  n_report;
    logic                   wr_open;
    logic                   wr_count;
    logic                   wr_drop;

    assign k_scale    = r_in_log2 - PRL_BURST_BIAS;
    assign burst_prod = (PRL_CNT_W + 1)'(r_burst) * (PRL_CNT_W + 1)'(k_scale);

    always_comb begin
        if (r_in_log2 <= PRL_BURST_KNEE) begin
            eff_burst = PRL_CNT_W'(r_burst);
        end else begin
            eff_burst = PRL_CNT_W'(burst_prod >> PRL_BURST_SHIFT);
        end
    end

    assign disabled    = (r_wlen == '0) || (r_burst == '0);
    assign elapsed     = r_in_ts - cur_start;
    // an unused pool, or a window that has run out; an earlier timestamp holds
    assign open_new    = (cur_start == '0) ||
                         ((r_in_ts >= cur_start) && (elapsed > PRL_TS_W'(r_wlen)));
    assign under_burst = cur_count <= eff_burst;

    always_comb begin
        n_admit  = 1'b1;
        n_report = '0;
        wr_open  = 1'b0;
        wr_count = 1'b0;
        wr_drop  = 1'b0;
        priority if (disabled) begin
            // pass through, touch nothing
        end else if (open_new) begin
            n_report = cur_drop;
            wr_open  = 1'b1;
        end else if (under_burst) begin
            wr_count = cur_count != PRL_CNT_MAX;
        end else begin
            n_admit = 1'b0;
            wr_drop = cur_drop != PRL_DROP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                r_win_start[p] <= '0;
                r_win_count[p] <= '0;
                r_drop_cnt[p]  <= '0;
            end
        end else if (fire) begin
            if (wr_open) begin
                r_win_start[r_in_pool] <= r_in_ts;
                r_win_count[r_in_pool] <= PRL_CNT_W'(1);
                r_drop_cnt[r_in_pool]  <= '0;
            end
            if (wr_count) begin
                r_win_count[r_in_pool] <= cur_count + PRL_CNT_W'(1);
            end
            if (wr_drop) begin
                r_drop_cnt[r_in_pool] <= cur_drop + PRL_DROP_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic                  r_admit;
    logic [PRL_DROP_W-1:0] r_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_admit  <= n_admit;
            r_report <= n_report;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_admit          = r_admit;
    assign o_dropped_report = r_report;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a dropped message never carries a drop report
    a_drop_no_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_admit) |-> (o_dropped_report == '0))
        else $error("dropped item carries a nonzero report");

    // the input side stalls only behind a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // a processed item shows up as a result in the next cycle
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (o_out_valid && (o_admit == $past(n_admit))))
        else $error("processed item lost on the way to the result register");

    // opening a window leaves the pool with one admitted message
    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && wr_open) |=> (r_win_count[$past(r_in_pool)] == PRL_CNT_W'(1)))
        else $error("new window does not start with a count of one");

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for per_priority_rate_limiter_core: directed and random messages
// checked against a predictor of the per-pool window state.
// Depends on prl_pkg and the core RTL; needs nothing else.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prl_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 6;
    // burst scaling: above the knee the burst becomes burst * (k - bias) / 4
    localparam int BURST_KNEE   = 20;
    localparam int BURST_BIAS   = 16;

    // one decision as the checker expects to see it
    typedef struct packed {
        logic                  admit;
        logic [PRL_DROP_W-1:0] report;
    } t_verdict;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    t_cfg_idx                  i_cfg_index;
    logic [PRL_CFG_DATA_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [PRL_LEVEL_W-1:0]    i_level;
    logic [PRL_SPACE_W-1:0]    i_free_space;
    logic [PRL_TS_W-1:0]       i_timestamp;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_admit;
    logic [PRL_DROP_W-1:0]     o_dropped_report;

    // predictor copy of the registers and of each pool
    logic [PRL_WLEN_W-1:0]  cfg_window;
    logic [PRL_BURST_W-1:0] cfg_burst;
    logic [PRL_TS_W-1:0]    pool_start [PRL_NUM_POOLS];
    logic [PRL_CNT_W-1:0]   pool_count [PRL_NUM_POOLS];
    logic [PRL_DROP_W-1:0]  pool_drops [PRL_NUM_POOLS];

    // decisions predicted at acceptance, oldest first
    t_verdict pending_verdicts [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned tx_calm_left;
    bit          quiet_tail;   // last part of the run: no idling on either side
    bit          tx_steady;    // sender offers items back to back
    bit          hold_req;     // ask the receiver for one long hold-off

    // running time for the random traffic, and the typical step between items
    logic [63:0] now_us;
    int unsigned step_us;

    per_priority_rate_limiter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_level          (i_level),
        .i_free_space     (i_free_space),
        .i_timestamp      (i_timestamp),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_admit          (o_admit),
        .o_dropped_report (o_dropped_report)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Decide one message and advance the pool it lands in.
    function automatic t_verdict rate_decide(
        input logic [PRL_LEVEL_W-1:0] level,
        input logic [PRL_SPACE_W-1:0] space,
        input logic [PRL_TS_W-1:0]    stamp
    );
        t_verdict    v;
        int unsigned pool;
        int unsigned k;
        int          b;
        logic [63:0] allowance;
        logic        opens;
        v.admit  = 1'b1;
        v.report = '0;
        // either register at zero lets everything through untouched
        if (cfg_window == '0 || cfg_burst == '0)
            return v;
        case (level)
            3'd0, 3'd1, 3'd2: pool = 0;
            3'd3:             pool = 1;
            3'd4:             pool = 2;
            3'd5, 3'd6:       pool = 3;
            default:          pool = 4;
        endcase
        if (pool >= PRL_NUM_POOLS)
            pool = PRL_NUM_POOLS - 1;
        // floor(log2(space)), zero for a space of 0 or 1
        k = 0;
        for (b = 1; b < PRL_SPACE_W; b++)
            if (space[b])
                k = b;
        if (k <= BURST_KNEE)
            allowance = 64'(cfg_burst);
        else
            allowance = (64'(cfg_burst) * 64'(k - BURST_BIAS)) >> 2;
        // an unused pool opens at once; an earlier stamp never expires a window
        if (pool_start[pool] == '0)
            opens = 1'b1;
        else if (stamp < pool_start[pool])
            opens = 1'b0;
        else
            opens = (stamp - pool_start[pool]) > 64'(cfg_window);
        if (opens) begin
            v.report         = pool_drops[pool];
            pool_drops[pool] = '0;
            pool_count[pool] = PRL_CNT_W'(1);
            pool_start[pool] = stamp;
        end else if (64'(pool_count[pool]) <= allowance) begin
            if (pool_count[pool] != '1)
                pool_count[pool] += 1'b1;
        end else begin
            if (pool_drops[pool] != '1)
                pool_drops[pool] += 1'b1;
            v.admit = 1'b0;
        end
        return v;
    endfunction

    // Compare every accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_verdict want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: admit=%0b report=%0d",
                                          o_admit, o_dropped_report));
            end else begin
                want = pending_verdicts.pop_front();
                if (o_admit !== want.admit)
                    report_mismatch($sformatf("admit %0b, expected %0b",
                                              o_admit, want.admit));
                if (o_dropped_report !== want.report)
                    report_mismatch($sformatf("dropped_report %0d, expected %0d",
                                              o_dropped_report, want.report));
            end
        end
    end

    // Receiver pacing: random stall bursts, calm stretches, one long hold on
    // request, and nothing at all once the quiet tail starts.
    initial begin : rx_pacing
        int unsigned hold_left;
        int unsigned stall_left;
        int unsigned calm_left;
        i_out_stall = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        calm_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_tail) begin
                i_out_stall <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (calm_left != 0) begin
                calm_left--;
                i_out_stall <= 1'b0;
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        stall_left = $urandom_range(1, 14) - 1;
                        i_out_stall <= 1'b1;
                    end
                    1: begin
                        calm_left = $urandom_range(10, 40);
                        i_out_stall <= 1'b0;
                    end
                    default: i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Offer one message, hold it until accepted, and record its decision.
    // Entered and left at a falling edge; valid stays high between
    // back-to-back items.
    task automatic send_msg(
        input logic [PRL_LEVEL_W-1:0] level,
        input logic [PRL_SPACE_W-1:0] space,
        input logic [PRL_TS_W-1:0]    stamp
    );
        int unsigned gap;
        gap = 0;
        if (!quiet_tail && !tx_steady) begin
            if (tx_calm_left != 0)
                tx_calm_left--;
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 14);
            else if ($urandom_range(0, 7) == 0)
                tx_calm_left = $urandom_range(10, 40);
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_level      <= level;
        i_free_space <= space;
        i_timestamp  <= stamp;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_verdicts.push_back(rate_decide(level, space, stamp));
        @(negedge i_clk);
    endtask

    // Drop valid and wait for the block to empty before touching registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx index, input logic [PRL_CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            PRL_CFG_WINDOW_LENGTH: cfg_window = data;
            PRL_CFG_BURST_LIMIT:   cfg_burst  = data[PRL_BURST_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Free space spread over log2 buckets 0 and 2 to 63, with the odd extreme.
    function automatic logic [PRL_SPACE_W-1:0] pick_space();
        logic [63:0] noise;
        int unsigned k;
        noise = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return 64'($urandom_range(0, 1));
            1:       return ($urandom_range(0, 1) != 0) ? '1 : noise;
            default: begin
                k = ($urandom_range(0, 1) != 0) ? $urandom_range(2, BURST_KNEE)
                                                : $urandom_range(BURST_KNEE + 1, 63);
                return (64'd1 << k) | (noise & ((64'd1 << k) - 64'd1));
            end
        endcase
    endfunction

    // Advance the running time: small steps, jumps to just around the window
    // edge, repeats of the same instant and the odd stamp from the past.
    function automatic logic [PRL_TS_W-1:0] pick_stamp();
        logic [63:0] stamp;
        case ($urandom_range(0, 15))
            10, 11: begin
                now_us += 64'(cfg_window) + 64'($urandom_range(0, 2));
                stamp = now_us;
            end
            12:      stamp = now_us - 64'($urandom_range(1, 40));
            13, 14:  stamp = now_us;
            default: begin
                now_us += 64'($urandom_range(0, step_us));
                stamp = now_us;
            end
        endcase
        if (stamp == '0)
            stamp = 64'd1;
        return stamp;
    endfunction

    // Reset register values, untouched pools: every first message opens.
    task automatic test_reset_defaults();
        send_msg(3'd0, 64'd0, 64'd1);
        send_msg(3'd2, 64'd1, 64'd1);
        send_msg(3'd3, '1, 64'd1);
        send_msg(3'd4, 64'd1 << 30, 64'd1);
        send_msg(3'd7, 64'd12345, 64'd1);
        settle();
    endtask

    // Fill a window, drop past the burst, hit the exact window length, go
    // back in time, then expire and collect the drop count.
    task automatic test_window_edges();
        write_reg(PRL_CFG_WINDOW_LENGTH, 32'd100);
        write_reg(PRL_CFG_BURST_LIMIT, 32'd2);
        send_msg(3'd3, 64'd4096, 64'd1000);
        send_msg(3'd3, 64'd4096, 64'd1001);
        send_msg(3'd3, 64'd4096, 64'd1002);
        send_msg(3'd3, 64'd4096, 64'd1003);
        send_msg(3'd3, 64'd4096, 64'd1100);
        send_msg(3'd3, 64'd4096, 64'd995);
        send_msg(3'd3, 64'd4096, 64'd1101);
        settle();
    endtask

    // Burst follows log2 of the free space: flat up to the knee, then scaled.
    // Upper data bits on the burst register must be ignored.
    task automatic test_burst_scaling();
        write_reg(PRL_CFG_WINDOW_LENGTH, '1);
        write_reg(PRL_CFG_BURST_LIMIT, 32'hABCD_0004);
        send_msg(3'd4, 64'd0, 64'd5000);
        send_msg(3'd4, 64'd1, 64'd5001);
        send_msg(3'd4, 64'd1 << 20, 64'd5002);
        send_msg(3'd4, 64'd1 << 20, 64'd5003);
        send_msg(3'd4, 64'd1 << 21, 64'd5004);
        send_msg(3'd4, 64'd1 << 22, 64'd5005);
        send_msg(3'd4, 64'd1 << 22, 64'd5006);
        send_msg(3'd4, '1, 64'd5007);
        settle();
    endtask

    // Zero window length, then zero burst: admit all, leave the pools alone.
    task automatic test_limiting_off();
        write_reg(PRL_CFG_WINDOW_LENGTH, '0);
        send_msg(3'd3, 64'd4096, 64'd1102);
        send_msg(3'd3, 64'd4096, 64'd1103);
        settle();
        write_reg(PRL_CFG_WINDOW_LENGTH, 32'd100);
        write_reg(PRL_CFG_BURST_LIMIT, 32'hFFFF_0000);
        send_msg(3'd3, 64'd4096, 64'd1104);
        send_msg(3'd3, 64'd4096, 64'd1105);
        settle();
    endtask

    // A zero stamp leaves its pool looking unused; the largest stamp opens a
    // window that later traffic can never expire, so keep it to the debug pool.
    task automatic test_time_extremes();
        write_reg(PRL_CFG_WINDOW_LENGTH, 32'd50);
        write_reg(PRL_CFG_BURST_LIMIT, 32'd1);
        send_msg(3'd5, 64'd100, 64'd0);
        send_msg(3'd6, 64'd100, 64'd10);
        send_msg(3'd7, 64'd100, '1);
        send_msg(3'd7, 64'd100, '1);
        send_msg(3'd7, 64'd100, '1);
        settle();
    endtask

    // Hold the result side off for a long stretch while items keep coming,
    // so the block fills and stalls its input; then wait for it to drain.
    task automatic test_output_backpressure();
        int i;
        write_reg(PRL_CFG_WINDOW_LENGTH, 32'd300);
        write_reg(PRL_CFG_BURST_LIMIT, 32'd3);
        step_us   = 50;
        now_us   += 64'h1_0000_0000;
        tx_steady = 1'b1;
        hold_req  = 1'b1;
        for (i = 0; i < 30; i++)
            send_msg(PRL_LEVEL_W'($urandom_range(0, 7)), pick_space(), pick_stamp());
        tx_steady = 1'b0;
        settle();
    endtask

    // Phases of random traffic, each under its own register setting; the jump
    // between phases expires every open window but the one from the largest stamp.
    task automatic test_random_traffic();
        int          phase;
        int          i;
        int unsigned n_items;
        logic [31:0] window_data;
        logic [31:0] burst_data;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    window_data = 32'd1;
                    burst_data  = 32'd1;
                end
                1: begin
                    window_data = '1;
                    burst_data  = '1;
                end
                3: begin
                    window_data = '0;
                    burst_data  = $urandom_range(1, 4);
                end
                4: begin
                    window_data = $urandom_range(20, 400);
                    burst_data  = {16'($urandom), 16'd0};
                end
                5: begin
                    window_data = $urandom;
                    burst_data  = $urandom_range(1, 6);
                end
                default: begin
                    window_data = $urandom_range(20, 400);
                    burst_data  = {16'($urandom), 16'($urandom_range(1, 6))};
                end
            endcase
            quiet_tail = (phase == 7);
            if ($urandom_range(0, 1) != 0) begin
                write_reg(PRL_CFG_WINDOW_LENGTH, window_data);
                write_reg(PRL_CFG_BURST_LIMIT, burst_data);
            end else begin
                write_reg(PRL_CFG_BURST_LIMIT, burst_data);
                write_reg(PRL_CFG_WINDOW_LENGTH, window_data);
            end
            step_us = (window_data == '0) ? 16 : window_data / 6 + 1;
            now_us += 64'h1_0000_0000 + 64'($urandom);
            // a disabled setting only needs a handful of messages
            n_items = (window_data == '0 || burst_data[15:0] == '0) ? 15 : 52;
            for (i = 0; i < n_items; i++)
                send_msg(PRL_LEVEL_W'($urandom_range(0, 7)), pick_space(), pick_stamp());
            settle();
        end
    endtask

    initial begin : main_sequence
        int p;
        i_rst_n      = 1'b0;
        i_cfg_wr_en  = 1'b0;
        i_cfg_index  = PRL_CFG_WINDOW_LENGTH;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_level      = '0;
        i_free_space = '0;
        i_timestamp  = '0;
        quiet_tail   = 1'b0;
        tx_steady    = 1'b0;
        hold_req     = 1'b0;
        tx_calm_left = 0;
        mismatch_count = 0;
        cycle_count  = 0;
        cfg_window   = PRL_WLEN_RESET;
        cfg_burst    = PRL_BURST_RESET;
        for (p = 0; p < PRL_NUM_POOLS; p++) begin
            pool_start[p] = '0;
            pool_count[p] = '0;
            pool_drops[p] = '0;
        end
        now_us  = 64'h1_0000_0000;
        step_us = 16;

        // synchronous reset held, then released on a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_window_edges();
        test_burst_scaling();
        test_limiting_off();
        test_time_extremes();
        test_output_backpressure();
        test_random_traffic();

        // let anything stray show up before the verdict
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
